// ===== sv/maxp_pkg.sv =====
`default_nettype none

package maxp_pkg;

  // Default sizes of the line store
  localparam int MAX_WIDTH_DEF = 256;
  localparam int MAX_WORDS_DEF = 64;

  // Lanes per channel word, fixed by the 32-bit payload
  localparam int LANES   = 4;
  localparam int LANE_W  = 8;
  localparam int WORD_W  = LANES * LANE_W;
  localparam int ADDR_W  = 22;

  // Register widths
  localparam int HEIGHT_W = 9;
  localparam int WIDTH_W  = 9;
  localparam int WORDS_W  = 7;
  localparam int STRIDE_W = 2;

  // APB port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Register map, word index on paddr[4:2]
  typedef enum logic [2:0] {
    REG_HEIGHT     = 3'd0,
    REG_WIDTH      = 3'd1,
    REG_WORDS      = 3'd2,
    REG_STRIDE     = 3'd3,
    REG_PAD_RIGHT  = 3'd4,
    REG_PAD_BOTTOM = 3'd5
  } reg_idx_t;

  localparam logic [STRIDE_W-1:0] STRIDE_TWO = STRIDE_W'(2);

  // Windows one word can close, in ascending output address
  typedef enum logic [1:0] {
    WIN_FULL   = 2'd0,
    WIN_RIGHT  = 2'd1,
    WIN_BOTTOM = 2'd2,
    WIN_CORNER = 2'd3
  } win_t;

  // Per-lane signed int8 maximum
  function automatic logic [WORD_W-1:0] lane_max(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int k = 0; k < LANES; k++) begin
      if ($signed(a[k*LANE_W +: LANE_W]) > $signed(b[k*LANE_W +: LANE_W])) begin
        r[k*LANE_W +: LANE_W] = a[k*LANE_W +: LANE_W];
      end else begin
        r[k*LANE_W +: LANE_W] = b[k*LANE_W +: LANE_W];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/maxpool_2x2_int8x4_core.sv =====
`default_nettype none

// 2x2 max pooling over four signed int8 lanes per word, stride 1 or 2, with
// optional one-pixel right/bottom padding at stride 1. Words stream in raster
// order (row, column, channel word); each result carries its output word
// address. The block takes one word per clock while the work stage is free
// to retire; each word passes through the work stage and then the result
// register. A word that closes more than one window (the right or bottom
// padded edge at stride 1) holds the input until its last window is sent,
// since the result port moves one beat per clock while out_ready allows.
// The line store needs no clearing pass after reset. Any write to a mapped
// register restarts the frame; write registers only while the block is idle.
module maxpool_2x2_int8x4_core
  import maxp_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // APB configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  // Input stream
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WORD_W-1:0] in_word,
  // Result stream
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [WORD_W-1:0] out_word,
  output logic      [ADDR_W-1:0] out_address,
  output logic                   run_last,
  output logic                   frame_last
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int SDEPTH = MAX_WIDTH * MAX_WORDS;
  localparam int SW  = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int DW  = ($clog2(MAX_WIDTH + 1) > WIDTH_W) ? $clog2(MAX_WIDTH + 1) : WIDTH_W;
  localparam int DD  = ($clog2(MAX_WORDS + 1) > WORDS_W) ? $clog2(MAX_WORDS + 1) : WORDS_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [HEIGHT_W-1:0] image_height;
  logic [WIDTH_W-1:0]  image_width;
  logic [WORDS_W-1:0]  channel_words;
  logic [STRIDE_W-1:0] pool_stride;
  logic                pad_right_on;
  logic                pad_bottom_on;
  logic                cfg_wr;
  logic                cfg_hit;
  reg_idx_t            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);
  // only a write to a mapped register restarts the frame
  assign cfg_hit = cfg_wr & (paddr[4:2] <= REG_PAD_BOTTOM);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_height  <= HEIGHT_W'(2);
      image_width   <= WIDTH_W'(2);
      channel_words <= WORDS_W'(1);
      pool_stride   <= STRIDE_TWO;
      pad_right_on  <= 1'b0;
      pad_bottom_on <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HEIGHT:     image_height  <= pwdata[HEIGHT_W-1:0];
        REG_WIDTH:      image_width   <= pwdata[WIDTH_W-1:0];
        REG_WORDS:      channel_words <= pwdata[WORDS_W-1:0];
        REG_STRIDE:     pool_stride   <= pwdata[STRIDE_W-1:0];
        REG_PAD_RIGHT:  pad_right_on  <= pwdata[0];
        REG_PAD_BOTTOM: pad_bottom_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_idx)
      REG_HEIGHT:     prdata = APB_DW'(image_height);
      REG_WIDTH:      prdata = APB_DW'(image_width);
      REG_WORDS:      prdata = APB_DW'(channel_words);
      REG_STRIDE:     prdata = APB_DW'(pool_stride);
      REG_PAD_RIGHT:  prdata = APB_DW'(pad_right_on);
      REG_PAD_BOTTOM: prdata = APB_DW'(pad_bottom_on);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effective geometry
  // ---------------------------------------------------------------------------
  logic [DW-1:0]     h_eff, wd_eff, oh, ow;
  logic [DD-1:0]     d_eff;
  logic              s2, pr, pb, map_ok;
  logic [ADDR_W-1:0] d_a, owd;

  always_comb begin
    // zero acts as one, oversize acts as the maximum
    if (image_height == '0) begin
      h_eff = DW'(1);
    end else if (DW'(image_height) > DW'(MAX_WIDTH)) begin
      h_eff = DW'(MAX_WIDTH);
    end else begin
      h_eff = DW'(image_height);
    end
    if (image_width == '0) begin
      wd_eff = DW'(1);
    end else if (DW'(image_width) > DW'(MAX_WIDTH)) begin
      wd_eff = DW'(MAX_WIDTH);
    end else begin
      wd_eff = DW'(image_width);
    end
    if (channel_words == '0) begin
      d_eff = DD'(1);
    end else if (DD'(channel_words) > DD'(MAX_WORDS)) begin
      d_eff = DD'(MAX_WORDS);
    end else begin
      d_eff = DD'(channel_words);
    end
    s2 = (pool_stride == STRIDE_TWO);
    pr = ~s2 & pad_right_on;
    pb = ~s2 & pad_bottom_on;
    if (s2) begin
      oh = h_eff >> 1;
      ow = wd_eff >> 1;
    end else begin
      oh = h_eff + DW'(pb) - DW'(1);
      ow = wd_eff + DW'(pr) - DW'(1);
    end
    map_ok = (oh != '0) && (ow != '0);
    d_a    = ADDR_W'(d_eff);
    owd    = ADDR_W'(ow) * d_a;
  end

  // ---------------------------------------------------------------------------
  // Position counters and output address bases
  // ---------------------------------------------------------------------------
  logic [CW-1:0]     row_cnt, col_cnt, row_cnt_next, col_cnt_next;
  logic [WW-1:0]     word_cnt, word_cnt_next;
  logic [ADDR_W-1:0] rb, cb, rb_next, cb_next;
  logic [ADDR_W-1:0] rb_cur, cb_cur;
  logic              w_last, c_last, r_last;
  logic              in_accept, b_leave;

  assign in_accept = in_valid & in_ready;

  always_comb begin
    w_last = (DD'(word_cnt) == d_eff - DD'(1));
    c_last = (DW'(col_cnt) == wd_eff - DW'(1));
    r_last = (DW'(row_cnt) == h_eff - DW'(1));
    // base at the first row/column of the frame
    rb_cur = (row_cnt == '0) ? (s2 ? '0 : ADDR_W'(0) - owd) : rb;
    cb_cur = (col_cnt == '0) ? (s2 ? '0 : ADDR_W'(0) - d_a) : cb;

    row_cnt_next  = row_cnt;
    col_cnt_next  = col_cnt;
    word_cnt_next = word_cnt;
    rb_next       = rb_cur;
    cb_next       = cb_cur;
    if (!w_last) begin
      word_cnt_next = word_cnt + WW'(1);
    end else begin
      word_cnt_next = '0;
      if (!c_last) begin
        col_cnt_next = col_cnt + CW'(1);
        if (!s2 || col_cnt[0]) begin
          cb_next = cb_cur + d_a;
        end
      end else begin
        col_cnt_next = '0;
        if (!r_last) begin
          row_cnt_next = row_cnt + CW'(1);
          if (!s2 || row_cnt[0]) begin
            rb_next = rb_cur + owd;
          end
        end else begin
          row_cnt_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row_cnt  <= '0;
      col_cnt  <= '0;
      word_cnt <= '0;
    end else if (in_accept) begin
      row_cnt  <= row_cnt_next;
      col_cnt  <= col_cnt_next;
      word_cnt <= word_cnt_next;
    end
  end

  // Bases are only read once their counter is nonzero
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rb <= rb_next;
      cb <= cb_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Window selection for the accepted beat
  // ---------------------------------------------------------------------------
  logic [3:0]        a_mask, a_last;
  logic [ADDR_W-1:0] a_addr;
  logic [SW-1:0]     a_sidx;
  logic              row_hit, col_hit, r_nz, c_nz;

  always_comb begin
    r_nz = (row_cnt != '0);
    c_nz = (col_cnt != '0);
    a_mask = '0;
    if (s2) begin
      a_mask[WIN_FULL] = row_cnt[0] & col_cnt[0];
      row_hit = (DW'(row_cnt >> 1) == oh - DW'(1));
      col_hit = (DW'(col_cnt >> 1) == ow - DW'(1));
    end else begin
      a_mask[WIN_FULL]   = r_nz & c_nz;
      a_mask[WIN_RIGHT]  = pr & c_last & r_nz;
      a_mask[WIN_BOTTOM] = pb & r_last & c_nz;
      a_mask[WIN_CORNER] = pr & pb & r_last & c_last;
      row_hit = (DW'(row_cnt) == oh);
      col_hit = (DW'(col_cnt) == ow);
    end
    a_mask = map_ok ? a_mask : '0;
    // last word of the output map
    a_last[WIN_FULL]   = row_hit & col_hit & w_last;
    a_last[WIN_RIGHT]  = row_hit & w_last;
    a_last[WIN_BOTTOM] = col_hit & w_last;
    a_last[WIN_CORNER] = w_last;
    a_addr = rb_cur + cb_cur + ADDR_W'(word_cnt);
    a_sidx = SW'(col_cnt) * SW'(MAX_WORDS) + SW'(word_cnt);
  end

  // ---------------------------------------------------------------------------
  // Line store and previous-pixel buffers: read on accept, write on retire
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] row_store [SDEPTH];
  logic [WORD_W-1:0] prev_cur  [MAX_WORDS];
  logic [WORD_W-1:0] prev_up   [MAX_WORDS];
  logic [WORD_W-1:0] up_rd, left_rd, ul_rd;
  logic [WORD_W-1:0] up_eff, left_eff, ul_eff;

  logic              b_valid;
  logic [WORD_W-1:0] b_v;
  logic [SW-1:0]     b_sidx;
  logic [WW-1:0]     b_w;
  logic [3:0]        b_pend, b_last;
  logic [ADDR_W-1:0] b_addr;
  logic              b_collide;

  always_ff @(posedge clk) begin
    if (b_leave) begin
      row_store[b_sidx] <= b_v;
    end
    if (in_accept) begin
      up_rd <= row_store[a_sidx];
    end
  end

  always_ff @(posedge clk) begin
    if (b_leave) begin
      prev_cur[b_w] <= b_v;
    end
    if (in_accept) begin
      left_rd <= prev_cur[word_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (b_leave) begin
      prev_up[b_w] <= up_eff;
    end
    if (in_accept) begin
      ul_rd <= prev_up[word_cnt];
    end
  end

  // Predecessor that retired on the edge of our read: forward its writes
  logic [WORD_W-1:0] last_v, last_up;
  logic [SW-1:0]     last_sidx;
  logic [WW-1:0]     last_w;

  always_ff @(posedge clk) begin
    if (b_leave) begin
      last_v    <= b_v;
      last_up   <= up_eff;
      last_sidx <= b_sidx;
      last_w    <= b_w;
    end
  end

  always_comb begin
    up_eff   = (b_collide && last_sidx == b_sidx) ? last_v : up_rd;
    left_eff = (b_collide && last_w == b_w) ? last_v : left_rd;
    ul_eff   = (b_collide && last_w == b_w) ? last_up : ul_rd;
  end

  // ---------------------------------------------------------------------------
  // Work stage: one beat, up to four windows emitted in order
  // ---------------------------------------------------------------------------
  logic              out_load, emit;
  logic [3:0]        pend_rest;
  win_t              sel;
  logic [WORD_W-1:0] sel_word;
  logic [ADDR_W-1:0] sel_addr;

  assign out_load  = ~out_valid | out_ready;
  assign pend_rest = b_pend & (b_pend - 4'd1);
  assign emit      = b_valid & (b_pend != '0) & out_load;
  assign b_leave   = b_valid & ((b_pend == '0) | ((pend_rest == '0) & out_load));
  assign in_ready  = ~b_valid | b_leave;

  always_comb begin
    priority if (b_pend[WIN_FULL]) begin
      sel = WIN_FULL;
    end else if (b_pend[WIN_RIGHT]) begin
      sel = WIN_RIGHT;
    end else if (b_pend[WIN_BOTTOM]) begin
      sel = WIN_BOTTOM;
    end else begin
      sel = WIN_CORNER;
    end
    unique case (sel)
      WIN_FULL: begin
        sel_word = lane_max(lane_max(ul_eff, up_eff), lane_max(left_eff, b_v));
        sel_addr = b_addr;
      end
      WIN_RIGHT: begin
        sel_word = lane_max(up_eff, b_v);
        sel_addr = b_addr + d_a;
      end
      WIN_BOTTOM: begin
        sel_word = lane_max(left_eff, b_v);
        sel_addr = b_addr + owd;
      end
      default: begin
        sel_word = b_v;
        sel_addr = b_addr + owd + d_a;
      end
    endcase
  end

  // Work stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_pend  <= '0;
    end else if (in_accept) begin
      b_valid <= 1'b1;
      b_pend  <= a_mask;
    end else if (b_leave) begin
      b_valid <= 1'b0;
      b_pend  <= '0;
    end else if (emit) begin
      b_pend  <= pend_rest;
    end
  end

  // Work stage payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_v       <= in_word;
      b_sidx    <= a_sidx;
      b_w       <= word_cnt;
      b_last    <= a_last;
      b_addr    <= a_addr;
      b_collide <= b_leave;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word    <= sel_word;
      out_address <= sel_addr;
      run_last    <= (pend_rest == '0);
      frame_last  <= b_last[sel];
    end
  end

endmodule

`default_nettype wire
